// File: rtl/gbr_pkg.sv
package gbr_pkg;

    localparam int NUM_PINS_DEF = 54;

    // Pins covered by one function-select word and by one pull word
    localparam int PINS_PER_FSEL = 10;
    localparam int PINS_PER_PULL = 16;
    localparam int BANK_BITS     = 32;

    // Access kinds carried in tuser
    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    // Word map
    localparam int ADDR_FSEL0     = 0;
    localparam int NUM_FSEL_WORDS = 6;
    localparam int ADDR_SET0      = 7;
    localparam int ADDR_CLR0      = 10;
    localparam int ADDR_LEV0      = 13;
    localparam int ADDR_LEGACY    = 37;
    localparam int ADDR_CLK0      = 38;
    localparam int ADDR_PULL0     = 57;
    localparam int NUM_PULL_WORDS = 4;

    // Pin codes
    localparam logic [2:0] FSEL_OUTPUT = 3'b001;
    localparam logic [1:0] PULL_NONE   = 2'b00;
    localparam logic [1:0] PULL_UP     = 2'b01;
    localparam logic [1:0] PULL_DOWN   = 2'b10;
    localparam logic [1:0] LEGACY_DOWN = 2'd1;
    localparam logic [1:0] LEGACY_UP   = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

// File: rtl/gbr_ctrl.sv
module gbr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gbr_pkg::t_cmd o_cmd
);
    import gbr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   capture, execute;

    assign o_in_ready  = (r_state == S_IDLE);
    assign capture     = i_in_valid && o_in_ready;
    // execute only when the result register is free or drains this cycle
    assign execute     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = '{capture: capture, execute: execute};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (execute) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/gbr_datapath.sv
module gbr_datapath #(
    parameter int NUM_PINS = gbr_pkg::NUM_PINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbr_pkg::t_cmd       i_cmd,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic [1:0]          i_func,
    input  logic [5:0]          i_word_addr,
    input  logic [31:0]         i_write_data,
    input  logic [NUM_PINS-1:0] i_pad_levels,
    output logic [31:0]         o_read_data,
    output logic [NUM_PINS-1:0] o_drive_levels,
    output logic [NUM_PINS-1:0] o_drive_enables,
    output logic [NUM_PINS-1:0] o_pull_up_mask,
    output logic [NUM_PINS-1:0] o_pull_down_mask
);
    import gbr_pkg::*;

    localparam int FSEL_W = NUM_FSEL_WORDS * BANK_BITS;
    localparam int PULL_W = NUM_PULL_WORDS * BANK_BITS;

    // captured access
    logic [1:0]          r_func;
    logic [5:0]          r_wa;
    logic [31:0]         r_wd;
    logic [NUM_PINS-1:0] r_pads;

    // architectural state
    logic [2:0]          r_fsel [NUM_PINS];
    logic [1:0]          r_pull [NUM_PINS];
    logic [NUM_PINS-1:0] r_latch;
    logic [NUM_PINS-1:0] r_pad_sample;
    logic [1:0]          r_legacy;
    logic                r_scheme;
    logic [31:0]         r_read_data;

    logic [FSEL_W-1:0]   fsel_flat;
    logic [PULL_W-1:0]   pull_flat;
    logic [63:0]         lev64;
    logic [1:0]          legacy_code;
    logic                wr;
    logic [31:0]         n_read_data;

    assign wr = i_cmd.execute && (r_func == FUNC_WRITE);

    always_comb begin
        case (r_legacy)
            LEGACY_DOWN: legacy_code = PULL_DOWN;
            LEGACY_UP:   legacy_code = PULL_UP;
            default:     legacy_code = PULL_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_wa   <= i_word_addr;
            r_wd   <= i_write_data;
            r_pads <= i_pad_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme     <= 1'b0;
            r_legacy     <= 2'b00;
            r_pad_sample <= '0;
        end else begin
            if (i_cfg_we) r_scheme <= i_cfg_wdata;
            if (wr && r_wa == 6'(ADDR_LEGACY)) r_legacy <= r_wd[1:0];
            if (i_cmd.execute && r_func == FUNC_SAMPLE) r_pad_sample <= r_pads;
        end
    end

    for (genvar gp = 0; gp < NUM_PINS; gp++) begin : g_pin
        localparam logic [5:0] FSEL_ADDR = 6'(ADDR_FSEL0 + gp / PINS_PER_FSEL);
        localparam int         FSEL_SH   = 3 * (gp % PINS_PER_FSEL);
        localparam logic [5:0] SET_ADDR  = 6'(ADDR_SET0 + gp / BANK_BITS);
        localparam logic [5:0] CLR_ADDR  = 6'(ADDR_CLR0 + gp / BANK_BITS);
        localparam logic [5:0] CLK_ADDR  = 6'(ADDR_CLK0 + gp / BANK_BITS);
        localparam int         BANK_BIT  = gp % BANK_BITS;
        localparam logic [5:0] PULL_ADDR = 6'(ADDR_PULL0 + gp / PINS_PER_PULL);
        localparam int         PULL_SH   = 2 * (gp % PINS_PER_PULL);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fsel[gp]  <= 3'b000;
                r_pull[gp]  <= PULL_NONE;
                r_latch[gp] <= 1'b0;
            end else if (wr) begin
                if (r_wa == FSEL_ADDR) r_fsel[gp] <= r_wd[FSEL_SH +: 3];
                if (r_wa == SET_ADDR && r_wd[BANK_BIT]) r_latch[gp] <= 1'b1;
                if (r_wa == CLR_ADDR && r_wd[BANK_BIT]) r_latch[gp] <= 1'b0;
                if (!r_scheme && r_wa == CLK_ADDR && r_wd[BANK_BIT]) begin
                    r_pull[gp] <= legacy_code;
                end
                if (r_scheme && r_wa == PULL_ADDR) r_pull[gp] <= r_wd[PULL_SH +: 2];
            end
        end

        assign fsel_flat[FSEL_SH + BANK_BITS * (gp / PINS_PER_FSEL) +: 3] = r_fsel[gp];
        assign pull_flat[2 * gp +: 2] = r_pull[gp];
        assign o_drive_enables[gp]    = (r_fsel[gp] == FSEL_OUTPUT);
        assign o_pull_up_mask[gp]     = (r_pull[gp] == PULL_UP);
        assign o_pull_down_mask[gp]   = (r_pull[gp] == PULL_DOWN);
    end

    // zero the select-word bits that no pin occupies
    for (genvar gw = 0; gw < NUM_FSEL_WORDS; gw++) begin : g_fsel_pad
        localparam int FIRST = gw * PINS_PER_FSEL;
        localparam int PINS  = (NUM_PINS - FIRST >= PINS_PER_FSEL) ? PINS_PER_FSEL
                             : (NUM_PINS - FIRST > 0) ? (NUM_PINS - FIRST) : 0;
        assign fsel_flat[BANK_BITS * gw + 3 * PINS +: BANK_BITS - 3 * PINS] = '0;
    end

    if (2 * NUM_PINS < PULL_W) begin : g_pull_pad
        assign pull_flat[PULL_W-1:2*NUM_PINS] = '0;
    end

    assign lev64 = 64'((r_latch & o_drive_enables) | (r_pad_sample & ~o_drive_enables));

    always_comb begin
        n_read_data = '0;
        if (r_func == FUNC_READ) begin
            for (int w = 0; w < NUM_FSEL_WORDS; w++) begin
                if (r_wa == 6'(ADDR_FSEL0 + w)) n_read_data = fsel_flat[BANK_BITS*w +: 32];
            end
            for (int w = 0; w < NUM_PULL_WORDS; w++) begin
                if (r_wa == 6'(ADDR_PULL0 + w)) n_read_data = pull_flat[BANK_BITS*w +: 32];
            end
            if (r_wa == 6'(ADDR_LEV0))     n_read_data = lev64[31:0];
            if (r_wa == 6'(ADDR_LEV0 + 1)) n_read_data = lev64[63:32];
            if (r_wa == 6'(ADDR_LEGACY))   n_read_data = {30'd0, r_legacy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_read_data <= n_read_data;
    end

    assign o_read_data    = r_read_data;
    assign o_drive_levels = r_latch;

endmodule

// File: rtl/gpio_bank_registers.sv
// Channel    | Direction | Transaction contents
// -----------+-----------+----------------------------------------------------------
// s_axis     | in        | tuser: func; tdata: word_addr, write_data, pad_levels
// m_axis     | out       | tdata: read_data, drive_levels, drive_enables, pull masks
// i_cfg      | in        | write strobe plus the pull_scheme bit, no read-back
//
// Each access is first captured into the access registers, then executed, which applies it
// to the register bank and loads the read word. The result register decouples the
// output side, so the next access is captured while a result waits; an access
// stalls in its execute cycle only while a result is still held. Reset is
// synchronous and clears every pin to input, no pull, latch low.
// Pin-state outputs follow the live bank and show the state after the held access.
module gpio_bank_registers #(
    parameter int NUM_PINS = gbr_pkg::NUM_PINS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // word_addr, write_data, pad_levels (low to high), zero-filled to bytes
    input  logic [((38+NUM_PINS+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data, drive_levels, drive_enables, pull_up_mask, pull_down_mask
    output logic [((32+4*NUM_PINS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata
);
    import gbr_pkg::*;

    localparam int OUT_W = ((32 + 4 * NUM_PINS + 7) / 8) * 8;

    t_cmd                cmd;
    logic [31:0]         read_data;
    logic [NUM_PINS-1:0] drive_levels;
    logic [NUM_PINS-1:0] drive_enables;
    logic [NUM_PINS-1:0] pull_up_mask;
    logic [NUM_PINS-1:0] pull_down_mask;

    // Sequence capture and execute, hold the result valid until taken
    gbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // Register bank, pull logic and read mux
    gbr_datapath #(
        .NUM_PINS (NUM_PINS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (s_axis_tuser),
        .i_word_addr      (s_axis_tdata[5:0]),
        .i_write_data     (s_axis_tdata[37:6]),
        .i_pad_levels     (s_axis_tdata[38 +: NUM_PINS]),
        .o_read_data      (read_data),
        .o_drive_levels   (drive_levels),
        .o_drive_enables  (drive_enables),
        .o_pull_up_mask   (pull_up_mask),
        .o_pull_down_mask (pull_down_mask)
    );

    // Pack result fields low to high, zero-fill to a byte boundary
    assign m_axis_tdata = OUT_W'({pull_down_mask, pull_up_mask, drive_enables,
                                  drive_levels, read_data});

endmodule
